>>> design/dd_pkg.sv
`timescale 1ns / 1ps
package dd_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 12;
  localparam int SPAN_W   = 17;
  localparam int ORDER_W  = 2;

  // Years are offset by 399 so that the leap count never goes negative.
  localparam int YOFF_W   = 13;
  localparam int SERIAL_W = 21;
  localparam int DOFF_W   = 9;

  localparam logic [YOFF_W-1:0] YEAR_OFFSET = 13'd399;
  localparam logic [8:0]        DAYS_YEAR   = 9'd365;

  // Reciprocal multipliers for division by 100 and 400 over 13-bit values.
  localparam int RECIP_SHIFT = 20;
  localparam logic [13:0] RECIP100 = 14'd10486;
  localparam logic [11:0] RECIP400 = 12'd2622;
  localparam int P100_W  = YOFF_W + 14;
  localparam int P400_W  = YOFF_W + 12;
  localparam int PY100_W = YEAR_W + 14;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic signed [ORDER_W-1:0] ORD_LATER   = 2'sb01;
  localparam logic signed [ORDER_W-1:0] ORD_EARLIER = 2'sb11;
  localparam logic signed [ORDER_W-1:0] ORD_SAME    = 2'sb00;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } dd_stage_en_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before m of a common year.
  function automatic logic [DOFF_W-1:0] month_cum(input logic [MONTH_W-1:0] m);
    logic [DOFF_W-1:0] cum;
    case (m)
      4'd1:    cum = 9'd0;
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

>>> design/dd_in_if.sv
`timescale 1ns / 1ps
interface dd_in_if;
  import dd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   first_day;
  logic [MONTH_W-1:0] first_month;
  logic [YEAR_W-1:0]  first_year;
  logic [DAY_W-1:0]   second_day;
  logic [MONTH_W-1:0] second_month;
  logic [YEAR_W-1:0]  second_year;

  modport source (
    output valid, first_day, first_month, first_year,
    output second_day, second_month, second_year,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
    input  second_day, second_month, second_year,
    output ready
  );
endinterface

>>> design/dd_out_if.sv
`timescale 1ns / 1ps
interface dd_out_if;
  import dd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [SPAN_W-1:0]         day_span;
  logic signed [ORDER_W-1:0] order;
  logic                      date_error;

  modport source (
    output valid, day_span, order, date_error,
    input  ready
  );

  modport sink (
    input  valid, day_span, order, date_error,
    output ready
  );
endinterface

>>> design/dd_date_serial.sv
`timescale 1ns / 1ps
module dd_date_serial #(
  parameter int MIN_YEAR = 1900,
  parameter int MAX_YEAR = 2100
) (
  input  logic                          clk,
  input  dd_pkg::dd_stage_en_t          en,
  input  logic [dd_pkg::DAY_W-1:0]      day,
  input  logic [dd_pkg::MONTH_W-1:0]    month,
  input  logic [dd_pkg::YEAR_W-1:0]     year,
  output logic [dd_pkg::SERIAL_W-1:0]   serial,
  output logic                          ok
);
  import dd_pkg::*;

  localparam int LIM_W = 14;
  localparam logic [LIM_W-1:0] YEAR_LO = LIM_W'(MIN_YEAR);
  localparam logic [LIM_W-1:0] YEAR_HI = LIM_W'(MAX_YEAR);

  // stage 1: offset year, products, month table
  logic [YOFF_W-1:0]   yy_next;
  logic [YOFF_W-1:0]   s1_yy;
  logic [SERIAL_W-1:0] s1_yy365;
  logic [P100_W-1:0]   s1_p100;
  logic [P400_W-1:0]   s1_p400;
  logic [PY100_W-1:0]  s1_py100;
  logic [YEAR_W-1:0]   s1_year;
  logic [MONTH_W-1:0]  s1_month;
  logic [DAY_W-1:0]    s1_day;
  logic [DAY_W-1:0]    s1_len;
  logic [DOFF_W-1:0]   s1_cum;
  logic                s1_ym_ok;

  assign yy_next = YOFF_W'(year) + YEAR_OFFSET;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_yy    <= yy_next;
      s1_yy365 <= SERIAL_W'(yy_next) * SERIAL_W'(DAYS_YEAR);
      s1_p100  <= P100_W'(yy_next) * P100_W'(RECIP100);
      s1_p400  <= P400_W'(yy_next) * P400_W'(RECIP400);
      s1_py100 <= PY100_W'(year) * PY100_W'(RECIP100);
      s1_year  <= year;
      s1_month <= month;
      s1_day   <= day;
      s1_len   <= month_len(month);
      s1_cum   <= month_cum(month);
      s1_ym_ok <= (LIM_W'(year) >= YEAR_LO) && (LIM_W'(year) <= YEAR_HI) &&
                  (month >= MONTH_JAN) && (month <= MONTH_DEC);
    end
  end

  // stage 2: leap rule, validity, year part and day offset
  logic [6:0]          q100;
  logic [4:0]          q400;
  logic [5:0]          qy100;
  logic                leap;
  logic                feb_extra;
  logic                late_extra;
  logic [DAY_W-1:0]    lim;
  logic [SERIAL_W-1:0] ypart_next;
  logic [DOFF_W-1:0]   doff_next;
  logic [SERIAL_W-1:0] s2_ypart;
  logic [DOFF_W-1:0]   s2_doff;
  logic                s2_ok;

  always_comb begin
    q100  = s1_p100[P100_W-1:RECIP_SHIFT];
    q400  = s1_p400[P400_W-1:RECIP_SHIFT];
    qy100 = s1_py100[PY100_W-1:RECIP_SHIFT];
    // centuries are leap only when the century count is a multiple of four
    leap  = (s1_year[1:0] == 2'b00) &&
            ((s1_year != YEAR_W'(YEAR_W'(qy100) * YEAR_W'(100))) || (qy100[1:0] == 2'b00));
    feb_extra  = leap && (s1_month == MONTH_FEB);
    late_extra = leap && (s1_month > MONTH_FEB);
    lim        = s1_len + DAY_W'(feb_extra);
    ypart_next = s1_yy365 + SERIAL_W'(s1_yy[YOFF_W-1:2]) - SERIAL_W'(q100) + SERIAL_W'(q400);
    doff_next  = s1_cum + DOFF_W'(late_extra) + DOFF_W'(s1_day);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_ypart <= ypart_next;
      s2_doff  <= doff_next;
      s2_ok    <= s1_ym_ok && (s1_day != '0) && (s1_day <= lim);
    end
  end

  // stage 3: serial day count
  always_ff @(posedge clk) begin
    if (en.s3) begin
      serial <= s2_ypart + SERIAL_W'(s2_doff);
      ok     <= s2_ok;
    end
  end

endmodule

>>> design/dd_compare.sv
`timescale 1ns / 1ps
module dd_compare (
  input  logic                              clk,
  input  logic                              en,
  input  logic [dd_pkg::SERIAL_W-1:0]       serial_a,
  input  logic                              ok_a,
  input  logic [dd_pkg::SERIAL_W-1:0]       serial_b,
  input  logic                              ok_b,
  output logic [dd_pkg::SPAN_W-1:0]         day_span,
  output logic signed [dd_pkg::ORDER_W-1:0] order,
  output logic                              date_error
);
  import dd_pkg::*;

  localparam logic [SERIAL_W-1:0] SPAN_MAX = SERIAL_W'((1 << SPAN_W) - 1);

  logic                      err;
  logic                      later;
  logic                      earlier;
  logic [SERIAL_W-1:0]       diff;
  logic [SPAN_W-1:0]         span_next;
  logic signed [ORDER_W-1:0] order_next;

  always_comb begin
    err     = !ok_a || !ok_b;
    later   = serial_a > serial_b;
    earlier = serial_a < serial_b;
    diff    = later ? (serial_a - serial_b) : (serial_b - serial_a);
    // saturate wide spans
    span_next  = (diff > SPAN_MAX) ? SPAN_MAX[SPAN_W-1:0] : diff[SPAN_W-1:0];
    order_next = later ? ORD_LATER : (earlier ? ORD_EARLIER : ORD_SAME);
    if (err) begin
      span_next  = '0;
      order_next = ORD_SAME;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_span   <= span_next;
      order      <= order_next;
      date_error <= err;
    end
  end

endmodule

>>> design/date_difference_days.sv
`timescale 1ns / 1ps
// An accepted transaction passes serial stages s1, s2, s3 and the compare
// register to spans. Throughput: one date pair per cycle while spans.ready
// holds; the four register stages each advance on their own, so bubbles
// close up while the output waits. Reset: rst (synchronous) clears the stage
// valid bits; the pipeline payload is left as it was.
module date_difference_days #(
  parameter int MIN_YEAR = 1900,
  parameter int MAX_YEAR = 2100
) (
  input  logic     clk,
  input  logic     rst,
  dd_in_if.sink    dates,
  dd_out_if.source spans
);
  import dd_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  dd_stage_en_t en;

  logic [SERIAL_W-1:0] serial_a;
  logic [SERIAL_W-1:0] serial_b;
  logic                ok_a;
  logic                ok_b;

  // a stage loads when empty or when its content moves on
  assign en4 = !v4 || spans.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign en.s1 = en1;
  assign en.s2 = en2;
  assign en.s3 = en3;

  assign dates.ready = en1;
  assign spans.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= dates.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  dd_date_serial #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_serial_a (
    .clk    (clk),
    .en     (en),
    .day    (dates.first_day),
    .month  (dates.first_month),
    .year   (dates.first_year),
    .serial (serial_a),
    .ok     (ok_a)
  );

  dd_date_serial #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_serial_b (
    .clk    (clk),
    .en     (en),
    .day    (dates.second_day),
    .month  (dates.second_month),
    .year   (dates.second_year),
    .serial (serial_b),
    .ok     (ok_b)
  );

  dd_compare u_compare (
    .clk        (clk),
    .en         (en4),
    .serial_a   (serial_a),
    .ok_a       (ok_a),
    .serial_b   (serial_b),
    .ok_b       (ok_b),
    .day_span   (spans.day_span),
    .order      (spans.order),
    .date_error (spans.date_error)
  );

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    spans.valid && spans.date_error |-> (spans.day_span == '0) && (spans.order == ORD_SAME))
    else $error("error result carries a non-zero span or order");

  a_same_zero: assert property (@(posedge clk) disable iff (rst)
    spans.valid && (spans.order == ORD_SAME) |-> (spans.day_span == '0))
    else $error("equal dates with a non-zero span");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !spans.valid)
    else $error("result valid straight after reset");

endmodule
